// File: rtl/crc8rwc_pkg.sv
`default_nettype none

package crc8rwc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 2 * BYTE_W;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] CRC_INIT_RESET = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY_RESET = 8'h31;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 1'b1;

    typedef enum logic [1:0] {
        POS_HIGH = 2'd0,
        POS_LOW  = 2'd1,
        POS_CRC  = 2'd2
    } pos_t;

    typedef struct packed {
        logic [BYTE_W-1:0] crc_init;
        logic [BYTE_W-1:0] crc_poly;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              crc_match;
        logic              all_match;
        logic              last_word;
    } word_result_t;

    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] r;
        r = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[BYTE_W-1]) begin
                r = {r[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                r = {r[BYTE_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/crc8rwc_cfg.sv
`default_nettype none

module crc8rwc_cfg
    import crc8rwc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CRC_INIT: cfg_next.crc_init = cfg_wdata;
                REG_CRC_POLY: cfg_next.crc_poly = cfg_wdata;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_init <= CRC_INIT_RESET;
            cfg_reg.crc_poly <= CRC_POLY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/crc8rwc_assembler.sv
`default_nettype none

module crc8rwc_assembler
    import crc8rwc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              first_byte,
    input  wire logic              final_byte,
    input  wire cfg_t              cfg,
    output logic                   emit,
    output word_result_t           result
);

    pos_t              pos_reg, pos_next;
    logic              ok_reg, ok_next;
    logic [BYTE_W-1:0] high_reg, high_next;
    logic [BYTE_W-1:0] low_reg, low_next;
    logic [BYTE_W-1:0] crc_reg, crc_next;

    pos_t pos_eff;
    logic ok_eff;
    logic match;

    always_comb begin
        pos_eff   = first_byte ? POS_HIGH : pos_reg;
        ok_eff    = first_byte | ok_reg;
        match     = (rx_byte == crc_reg);
        pos_next  = pos_reg;
        ok_next   = ok_reg;
        high_next = high_reg;
        low_next  = low_reg;
        crc_next  = crc_reg;
        emit      = 1'b0;
        result.data_word = {high_reg, low_reg};
        result.crc_match = match;
        result.all_match = ok_eff & match;
        result.last_word = final_byte;
        if (accept) begin
            ok_next = ok_eff;
            unique case (pos_eff)
                POS_LOW: begin
                    low_next = rx_byte;
                    crc_next = crc8_byte(crc_reg, rx_byte, cfg.crc_poly);
                    pos_next = POS_CRC;
                end
                POS_CRC: begin
                    emit     = 1'b1;
                    ok_next  = ok_eff & match;
                    pos_next = POS_HIGH;
                end
                default: begin
                    high_next = rx_byte;
                    crc_next  = crc8_byte(cfg.crc_init, rx_byte, cfg.crc_poly);
                    pos_next  = POS_LOW;
                end
            endcase
            if (final_byte) begin
                pos_next = POS_HIGH;
                ok_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HIGH;
            ok_reg  <= 1'b1;
        end else begin
            pos_reg <= pos_next;
            ok_reg  <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        high_reg <= high_next;
        low_reg  <= low_next;
        crc_reg  <= crc_next;
    end

    a_emit_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> accept)
        else $error("word emitted without an accepted byte");

    a_high_to_low: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pos_eff == POS_HIGH && !final_byte |=> pos_reg == POS_LOW)
        else $error("high byte did not advance to low byte");

    a_final_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && final_byte |=> pos_reg == POS_HIGH && ok_reg)
        else $error("final byte did not restart the response");

    a_emit_on_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> pos_eff == POS_CRC)
        else $error("word emitted off the CRC byte");

endmodule

`default_nettype wire

// File: rtl/crc8rwc_out_reg.sv
`default_nettype none

module crc8rwc_out_reg
    import crc8rwc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load,
    input  wire word_result_t result_in,
    input  wire logic         m_ready,
    output logic              m_valid,
    output logic              space,
    output word_result_t      result_out
);

    logic         valid_reg, valid_next;
    word_result_t data_reg, data_next;

    always_comb begin
        space      = !valid_reg || m_ready;
        valid_next = load ? 1'b1 : (valid_reg && !m_ready);
        data_next  = load ? result_in : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid    = valid_reg;
    assign result_out = data_reg;

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid && result_out == $past(result_in))
        else $error("loaded word not presented");

endmodule

`default_nettype wire

// File: rtl/crc8_response_word_checker_core.sv
`default_nettype none

// Checks a sensor response that arrives one byte per transaction in groups of
// high byte, low byte and CRC-8 byte. The CRC (MSB first, polynomial and seed
// set by crc_poly and crc_init) runs over the two data bytes; on each CRC byte
// one result carries the word, its match flag, a sticky all-words-matched flag
// and the last-word mark. s_first_byte restarts a response; s_final_byte ends
// it and drops a partial group. One byte is taken every cycle; input stalls
// only while the output register is full and not being read. The CRC of a
// byte is eight unrolled XOR steps between the state registers, and the result
// appears in the output register the cycle after its CRC byte is taken.

module crc8_response_word_checker_core
    import crc8rwc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_rx_byte,
    input  wire logic                 s_first_byte,
    input  wire logic                 s_final_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [WORD_W-1:0]         m_data_word,
    output logic                      m_crc_match,
    output logic                      m_all_match,
    output logic                      m_last_word
);

    cfg_t         cfg;
    logic         accept;
    logic         emit;
    logic         space;
    word_result_t result;
    word_result_t result_q;

    assign s_ready = space;
    assign accept  = s_valid && space;

    crc8rwc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    crc8rwc_assembler u_assembler (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_rx_byte),
        .first_byte (s_first_byte),
        .final_byte (s_final_byte),
        .cfg        (cfg),
        .emit       (emit),
        .result     (result)
    );

    crc8rwc_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (emit),
        .result_in  (result),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .space      (space),
        .result_out (result_q)
    );

    assign m_data_word = result_q.data_word;
    assign m_crc_match = result_q.crc_match;
    assign m_all_match = result_q.all_match;
    assign m_last_word = result_q.last_word;

endmodule

`default_nettype wire
